/* rtl/core/lps_pkg.sv */
// Shared types, codes and sizes for the lottery process scheduler.
`timescale 1ns / 1ps
package lps_pkg;

    localparam int NUM_SLOTS_DEF = 64;
    localparam int NUM_QUEUES    = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int DIVIDEND_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TOP_QUEUE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_QUEUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_QUANTUM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TICKETS  = 2'd3;

    localparam logic [2:0] ACT_START_SYS = 3'd0;
    localparam logic [2:0] ACT_START_USR = 3'd1;
    localparam logic [2:0] ACT_STOP      = 3'd2;
    localparam logic [2:0] ACT_OOQ       = 3'd3;
    localparam logic [2:0] ACT_TICKETS   = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_IN_USE = 3'd1;
    localparam logic [2:0] ST_BAD_PRIO   = 3'd2;
    localparam logic [2:0] ST_BUSY       = 3'd3;
    localparam logic [2:0] ST_NO_TICKETS = 3'd4;

    typedef struct packed {
        logic [3:0]  prio;
        logic [15:0] slice;
        logic [15:0] tickets;
    } slot_rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PARENT,
        S_SLOT,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_GO,
        S_DIV_WAIT,
        S_PICK_RD,
        S_PICK_CHK,
        S_RESULT
    } state_t;

endpackage

/* rtl/core/lps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/lps_mod.sv */
// Restoring remainder unit: one dividend bit per cycle.
`timescale 1ns / 1ps
module lps_mod #(
    parameter int DIV_W = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lps_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [DIV_W-1:0]              divisor,
    output logic                          done,
    output logic [DIV_W-1:0]              remainder
);

    localparam int CNT_W = $clog2(lps_pkg::DIVIDEND_W);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [DIV_W-1:0]               rem_reg, rem_next;
    logic [lps_pkg::DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0]               dsr_reg, dsr_next;
    logic [DIV_W:0]                 trial;

    // Shift in one dividend bit and subtract when it fits
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        trial     = {rem_reg, dvd_reg[lps_pkg::DIVIDEND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(lps_pkg::DIVIDEND_W - 1);
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            dvd_next = {dvd_reg[lps_pkg::DIVIDEND_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/core/lottery_process_scheduler.sv */
// Top level: process table, request sequencer and lottery walk.
//
// Channel  Dir  Handshake              Beat
// in       in   in_valid / in_stall    action, slot, parent_slot, level_or_delta,
//                                      quantum, random_value
// out      out  out_valid / out_stall  status, sched_valid, sched_slot,
//                                      sched_priority, sched_time_slice
// cfg      in   cfg_we                 cfg_index, cfg_data
//
// One beat at a time; each request ends with an output beat.
// A lottery makes two walks over the table RAM and runs a 32-step remainder
// unit between them.
// Reset clears the in-use and system bits at once; the table RAM needs no clear.
// in_stall is high from acceptance until the result beat is taken.
`timescale 1ns / 1ps
module lottery_process_scheduler #(
    parameter int NUM_SLOTS = lps_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [2:0]                      action,
    input  logic [5:0]                      slot,
    input  logic [5:0]                      parent_slot,
    input  logic signed [8:0]               level_or_delta,
    input  logic [15:0]                     quantum,
    input  logic [31:0]                     random_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic                            sched_valid,
    output logic [5:0]                      sched_slot,
    output logic [3:0]                      sched_priority,
    output logic [15:0]                     sched_time_slice,
    input  logic                            cfg_we,
    input  logic [lps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lps_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(NUM_SLOTS);
    localparam int TOT_W = 16 + IDX_W;
    localparam int REC_W = $bits(lps_pkg::slot_rec_t);

    lps_pkg::state_t state_reg, state_next;

    logic [3:0]  top_q_reg, bot_q_reg;
    logic [15:0] uq_reg, def_tix_reg;

    logic [NUM_SLOTS-1:0] in_use_reg, in_use_next;
    logic [NUM_SLOTS-1:0] sys_reg, sys_next;

    logic [2:0]        act_reg;
    logic [5:0]        slot_reg, par_reg;
    logic signed [8:0] lvl_reg;
    logic [15:0]       qnt_reg;
    logic [31:0]       rand_reg;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W-1:0] draw_reg, draw_next;

    logic        ov_reg, ov_next;
    logic [2:0]  st_reg, st_next;
    logic        sv_reg, sv_next;
    logic [5:0]  ss_reg, ss_next;
    logic [3:0]  sp_reg, sp_next;
    logic [15:0] sl_reg, sl_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr, ram_raddr;
    lps_pkg::slot_rec_t   ram_wrec, rd_rec;
    logic [REC_W-1:0]     rd_data;

    logic             div_start, div_done;
    logic [TOT_W-1:0] div_rem;

    logic [IDX_W-1:0]   s_idx, p_idx;
    logic               s_ok, p_ok, last_idx, pool_hit;
    logic signed [17:0] tix_sum;
    logic [15:0]        tix_sat;

    assign s_idx    = IDX_W'(slot_reg);
    assign p_idx    = IDX_W'(par_reg);
    assign s_ok     = 32'(slot_reg) < 32'(NUM_SLOTS);
    assign p_ok     = 32'(par_reg) < 32'(NUM_SLOTS);
    assign last_idx = idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign rd_rec   = lps_pkg::slot_rec_t'(rd_data);
    assign pool_hit = in_use_reg[idx_reg] && !sys_reg[idx_reg] && rd_rec.prio == bot_q_reg;
    assign tix_sum  = $signed({2'b00, rd_rec.tickets}) + 18'(lvl_reg);
    assign tix_sat  = tix_sum[17] ? 16'd0 : (tix_sum[16] ? 16'hFFFF : tix_sum[15:0]);

    lps_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wrec),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    lps_mod #(
        .DIV_W (TOT_W)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rand_reg),
        .divisor   (total_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Sequence one request and build its result
    always_comb
    begin
        state_next  = state_reg;
        in_use_next = in_use_reg;
        sys_next    = sys_reg;
        idx_next    = idx_reg;
        total_next  = total_reg;
        draw_next   = draw_reg;
        ov_next     = ov_reg;
        st_next     = st_reg;
        sv_next     = sv_reg;
        ss_next     = ss_reg;
        sp_next     = sp_reg;
        sl_next     = sl_reg;
        ram_we      = 1'b0;
        ram_waddr   = s_idx;
        ram_wrec    = rd_rec;
        ram_raddr   = s_idx;
        div_start   = 1'b0;

        unique case (state_reg)
            lps_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lps_pkg::S_DECODE;
                end
            end

            lps_pkg::S_DECODE:
            begin
                state_next = lps_pkg::S_RESULT;
                st_next    = lps_pkg::ST_OK;
                sv_next    = 1'b0;
                ss_next    = '0;
                sp_next    = '0;
                sl_next    = '0;
                if (act_reg > lps_pkg::ACT_TICKETS)
                begin
                    st_next = lps_pkg::ST_OK;
                end
                else if (!s_ok)
                begin
                    st_next = lps_pkg::ST_NOT_IN_USE;
                end
                else if (act_reg == lps_pkg::ACT_START_SYS
                         || act_reg == lps_pkg::ACT_START_USR)
                begin
                    if (in_use_reg[s_idx])
                    begin
                        st_next = lps_pkg::ST_BUSY;
                    end
                    else if (lvl_reg[8] || lvl_reg[7:0] >= 8'(lps_pkg::NUM_QUEUES))
                    begin
                        st_next = lps_pkg::ST_BAD_PRIO;
                    end
                    else if (act_reg == lps_pkg::ACT_START_SYS)
                    begin
                        ram_we              = 1'b1;
                        ram_wrec.prio       = lvl_reg[3:0];
                        ram_wrec.slice      = qnt_reg;
                        ram_wrec.tickets    = '0;
                        in_use_next[s_idx]  = 1'b1;
                        sys_next[s_idx]     = 1'b1;
                        sv_next             = 1'b1;
                        ss_next             = slot_reg;
                        sp_next             = lvl_reg[3:0];
                        sl_next             = qnt_reg;
                    end
                    else if (!p_ok || !in_use_reg[p_idx])
                    begin
                        st_next = lps_pkg::ST_NOT_IN_USE;
                    end
                    else
                    begin
                        ram_raddr  = p_idx;
                        state_next = lps_pkg::S_PARENT;
                    end
                end
                else if (!in_use_reg[s_idx])
                begin
                    st_next = lps_pkg::ST_NOT_IN_USE;
                end
                else if (act_reg == lps_pkg::ACT_STOP)
                begin
                    in_use_next[s_idx] = 1'b0;
                end
                else
                begin
                    state_next = lps_pkg::S_SLOT;
                end
            end

            lps_pkg::S_PARENT:
            begin
                ram_we             = 1'b1;
                ram_wrec.prio      = bot_q_reg;
                ram_wrec.slice     = rd_rec.slice;
                ram_wrec.tickets   = def_tix_reg;
                in_use_next[s_idx] = 1'b1;
                sys_next[s_idx]    = 1'b0;
                sv_next            = 1'b1;
                ss_next            = slot_reg;
                sp_next            = bot_q_reg;
                sl_next            = rd_rec.slice;
                state_next         = lps_pkg::S_RESULT;
            end

            lps_pkg::S_SLOT:
            begin
                state_next = lps_pkg::S_RESULT;
                sv_next    = 1'b1;
                ss_next    = slot_reg;
                sp_next    = rd_rec.prio;
                sl_next    = rd_rec.slice;
                if (act_reg == lps_pkg::ACT_TICKETS)
                begin
                    ram_we           = 1'b1;
                    ram_wrec.tickets = tix_sat;
                end
                else if (sys_reg[s_idx])
                begin
                    sv_next = 1'b1;
                end
                else if (rd_rec.prio == top_q_reg)
                begin
                    ram_we         = 1'b1;
                    ram_wrec.prio  = bot_q_reg;
                    ram_wrec.slice = '0;
                    sp_next        = bot_q_reg;
                    sl_next        = '0;
                end
                else if (rd_rec.prio == bot_q_reg)
                begin
                    sv_next = 1'b0;
                    ss_next = '0;
                    sp_next = '0;
                    sl_next = '0;
                    if (top_q_reg > bot_q_reg)
                    begin
                        st_next = lps_pkg::ST_NO_TICKETS;
                    end
                    else
                    begin
                        idx_next   = '0;
                        total_next = '0;
                        state_next = lps_pkg::S_SUM_RD;
                    end
                end
                else
                begin
                    sv_next = 1'b0;
                    ss_next = '0;
                    sp_next = '0;
                    sl_next = '0;
                end
            end

            lps_pkg::S_SUM_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = lps_pkg::S_SUM_ACC;
            end

            lps_pkg::S_SUM_ACC:
            begin
                if (pool_hit)
                begin
                    total_next = total_reg + TOT_W'(rd_rec.tickets);
                end
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? lps_pkg::S_DIV_GO : lps_pkg::S_SUM_RD;
            end

            lps_pkg::S_DIV_GO:
            begin
                if (total_reg == '0)
                begin
                    st_next    = lps_pkg::ST_NO_TICKETS;
                    state_next = lps_pkg::S_RESULT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = lps_pkg::S_DIV_WAIT;
                end
            end

            lps_pkg::S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    draw_next  = div_rem;
                    idx_next   = '0;
                    state_next = lps_pkg::S_PICK_RD;
                end
            end

            lps_pkg::S_PICK_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = lps_pkg::S_PICK_CHK;
            end

            lps_pkg::S_PICK_CHK:
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? lps_pkg::S_RESULT : lps_pkg::S_PICK_RD;
                if (last_idx)
                begin
                    st_next = lps_pkg::ST_NO_TICKETS;
                end
                if (pool_hit && rd_rec.tickets != '0)
                begin
                    if (TOT_W'(rd_rec.tickets) <= draw_reg)
                    begin
                        draw_next = draw_reg - TOT_W'(rd_rec.tickets);
                    end
                    else
                    begin
                        // Winner: raise to the top queue
                        ram_we         = 1'b1;
                        ram_waddr      = idx_reg;
                        ram_wrec.prio  = top_q_reg;
                        ram_wrec.slice = uq_reg;
                        st_next        = lps_pkg::ST_OK;
                        sv_next        = 1'b1;
                        ss_next        = 6'(idx_reg);
                        sp_next        = top_q_reg;
                        sl_next        = uq_reg;
                        state_next     = lps_pkg::S_RESULT;
                    end
                end
            end

            lps_pkg::S_RESULT:
            begin
                ov_next = 1'b1;
                if (ov_reg && !out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = lps_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = lps_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lps_pkg::S_IDLE;
            in_use_reg  <= '0;
            sys_reg     <= '0;
            ov_reg      <= 1'b0;
            top_q_reg   <= 4'd0;
            bot_q_reg   <= 4'd14;
            uq_reg      <= 16'd200;
            def_tix_reg <= 16'd20;
        end
        else
        begin
            state_reg  <= state_next;
            in_use_reg <= in_use_next;
            sys_reg    <= sys_next;
            ov_reg     <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lps_pkg::CFG_TOP_QUEUE:    top_q_reg   <= cfg_data[3:0];
                    lps_pkg::CFG_BOTTOM_QUEUE: bot_q_reg   <= cfg_data[3:0];
                    lps_pkg::CFG_USER_QUANTUM: uq_reg      <= cfg_data;
                    lps_pkg::CFG_DEF_TICKETS:  def_tix_reg <= cfg_data;
                    default:                   top_q_reg   <= top_q_reg;
                endcase
            end
        end
    end

    // Payload: capture the request beat, hold walk and result values
    always_ff @(posedge clk)
    begin
        if (state_reg == lps_pkg::S_IDLE && in_valid)
        begin
            act_reg  <= action;
            slot_reg <= slot;
            par_reg  <= parent_slot;
            lvl_reg  <= level_or_delta;
            qnt_reg  <= quantum;
            rand_reg <= random_value;
        end
        idx_reg   <= idx_next;
        total_reg <= total_next;
        draw_reg  <= draw_next;
        st_reg    <= st_next;
        sv_reg    <= sv_next;
        ss_reg    <= ss_next;
        sp_reg    <= sp_next;
        sl_reg    <= sl_next;
    end

    assign in_stall         = state_reg != lps_pkg::S_IDLE;
    assign out_valid        = ov_reg;
    assign status           = st_reg;
    assign sched_valid      = sv_reg;
    assign sched_slot       = ss_reg;
    assign sched_priority   = sp_reg;
    assign sched_time_slice = sl_reg;

endmodule
